### sv/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
`timescale 1ns / 1ps
package wsd_pkg;

    localparam logic [15:0] RESET_MAX_PAYLOAD = 16'd10240;
    localparam logic [3:0]  OP_CLOSE          = 4'h8;
    localparam logic [3:0]  OP_PING           = 4'h9;
    localparam logic [3:0]  OP_DATA_RSV_LO    = 4'd3;
    localparam logic [3:0]  OP_DATA_RSV_HI    = 4'd7;
    localparam logic [3:0]  OP_CTRL_RSV_LO    = 4'd11;
    localparam logic [3:0]  OP_CTRL_RSV_HI    = 4'd15;
    localparam logic [6:0]  CTRL_MAX_LEN      = 7'd125;
    localparam logic [6:0]  LEN_CODE16        = 7'd126;
    localparam logic [6:0]  LEN_CODE64        = 7'd127;
    localparam logic [2:0]  EXT16_BYTES       = 3'd2;
    localparam logic [2:0]  EXT64_BYTES       = 3'd0;   // eight bytes, counter wraps
    localparam logic [2:0]  KEY_BYTES         = 3'd4;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_KEY   = 3'd4,
        PH_DATA  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        REPLY_NONE  = 2'd0,
        REPLY_PONG  = 2'd1,
        REPLY_CLOSE = 2'd2
    } reply_t;

    // One queued result: raw byte plus the key byte it is unmasked with.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic [7:0] key;
        logic       eof;
        logic [3:0] opcode;
        logic       fin;
        reply_t     reply;
        logic       status;
    } act_t;

endpackage

### sv/wsd_front.sv
// Header parser: tracks frame phase, length and key, and queues at most one result per byte.
`timescale 1ns / 1ps
module wsd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_data,
    input  logic          acc,
    input  logic [7:0]    rx_byte,
    output logic          push,
    output wsd_pkg::act_t act
);
    import wsd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] rem_reg, rem_next;
    logic        halted_reg, halted_next;
    logic [15:0] max_payload_reg;

    // decisions for the result builder
    logic        do_fail, do_finish, do_emit, res_has;
    logic [7:0]  res_key;
    reply_t      res_reply;

    logic        len_done, pay_start;
    logic [63:0] rem_dec;

    always_comb
    begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        rem_next    = rem_reg;
        halted_next = halted_reg;
        do_fail     = 1'b0;
        do_finish   = 1'b0;
        do_emit     = 1'b0;
        res_has     = 1'b0;
        res_key     = 8'd0;
        len_done    = 1'b0;
        pay_start   = 1'b0;
        rem_dec     = (rem_reg != 64'd0) ? rem_reg - 64'd1 : 64'd0;

        if (acc && !halted_reg)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    mask_next = rx_byte[7];
                    key_next  = 32'd0;
                    idx_next  = 3'd0;
                    rem_next  = 64'd0;
                    if (opcode_reg >= OP_CLOSE && rx_byte[6:0] > CTRL_MAX_LEN)
                        do_fail = 1'b1;
                    else if (rx_byte[6:0] == LEN_CODE16)
                        phase_next = PH_EXT16;
                    else if (rx_byte[6:0] == LEN_CODE64)
                        phase_next = PH_EXT64;
                    else
                    begin
                        rem_next = {57'd0, rx_byte[6:0]};
                        len_done = 1'b1;
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    rem_next = {rem_reg[55:0], rx_byte};
                    idx_next = idx_reg + 3'd1;
                    if (idx_next == ((phase_reg == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES))
                    begin
                        idx_next = 3'd0;
                        len_done = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    idx_next = idx_reg + 3'd1;
                    if (idx_next >= KEY_BYTES)
                        pay_start = 1'b1;
                end
                PH_DATA:
                begin
                    case (idx_reg[1:0])
                        2'd0:    res_key = key_reg[31:24];
                        2'd1:    res_key = key_reg[23:16];
                        2'd2:    res_key = key_reg[15:8];
                        default: res_key = key_reg[7:0];
                    endcase
                    res_has  = 1'b1;
                    idx_next = {1'b0, idx_reg[1:0] + 2'd1};
                    rem_next = rem_dec;
                    if (rem_dec == 64'd0)
                        do_finish = 1'b1;
                    else
                        do_emit = 1'b1;
                end
                default:
                begin
                    // first header byte; unused phase codes land here too
                    fin_next    = rx_byte[7];
                    opcode_next = rx_byte[3:0];
                    mask_next   = 1'b0;
                    idx_next    = 3'd0;
                    key_next    = 32'd0;
                    rem_next    = 64'd0;
                    if (rx_byte[6:4] != 3'd0)
                        do_fail = 1'b1;
                    else if (opcode_next inside {[OP_DATA_RSV_LO:OP_DATA_RSV_HI],
                                                 [OP_CTRL_RSV_LO:OP_CTRL_RSV_HI]})
                        do_fail = 1'b1;
                    else if (opcode_next >= OP_CLOSE && !rx_byte[7])
                        do_fail = 1'b1;
                    else
                        phase_next = PH_HDR1;
                end
            endcase

            if (len_done)
            begin
                if (rem_next > {48'd0, max_payload_reg})
                    do_fail = 1'b1;
                else if (mask_next)
                begin
                    phase_next = PH_KEY;
                    idx_next   = 3'd0;
                    key_next   = 32'd0;
                end
                else
                    pay_start = 1'b1;
            end

            if (pay_start)
            begin
                idx_next = 3'd0;
                if (rem_next == 64'd0)
                    do_finish = 1'b1;
                else
                    phase_next = PH_DATA;
            end

            if (do_fail)
            begin
                halted_next = 1'b1;
                phase_next  = PH_HDR0;
            end

            if (do_finish)
            begin
                phase_next = PH_HDR0;
                idx_next   = 3'd0;
                if (fin_next && opcode_next == OP_CLOSE)
                    halted_next = 1'b1;
            end
        end
    end

    // reply for a completed frame
    always_comb
    begin
        res_reply = REPLY_NONE;
        if (fin_next && opcode_next == OP_CLOSE)
            res_reply = REPLY_CLOSE;
        else if (fin_next && opcode_next == OP_PING)
            res_reply = REPLY_PONG;
    end

    // result builder
    always_comb
    begin
        push         = do_fail || do_finish || do_emit;
        act.has_byte = res_has && !do_fail;
        act.data     = (res_has && !do_fail) ? rx_byte : 8'd0;
        act.key      = (res_has && !do_fail) ? res_key : 8'd0;
        act.eof      = do_finish;
        act.opcode   = opcode_next;
        act.fin      = fin_next;
        act.reply    = do_finish ? res_reply : REPLY_NONE;
        act.status   = do_fail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR0;
            fin_reg         <= 1'b0;
            opcode_reg      <= 4'd0;
            mask_reg        <= 1'b0;
            idx_reg         <= 3'd0;
            key_reg         <= 32'd0;
            rem_reg         <= 64'd0;
            halted_reg      <= 1'b0;
            max_payload_reg <= RESET_MAX_PAYLOAD;
        end
        else
        begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            idx_reg    <= idx_next;
            key_reg    <= key_next;
            rem_reg    <= rem_next;
            halted_reg <= halted_next;
            if (cfg_we)
                max_payload_reg <= cfg_data;
        end
    end

endmodule

### sv/wsd_queue.sv
// Two-entry queue between the parser and the output stage.
`timescale 1ns / 1ps
module wsd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  wsd_pkg::act_t wr_item,
    input  logic          pop,
    output wsd_pkg::act_t rd_item,
    output logic          empty,
    output logic          full
);
    import wsd_pkg::*;

    act_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

### sv/wsd_back.sv
// Output stage: unmasks the queued byte and holds the result until taken.
`timescale 1ns / 1ps
module wsd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  wsd_pkg::act_t item,
    input  logic          empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          has_byte,
    output logic [7:0]    payload_byte,
    output logic          end_of_frame,
    output logic [3:0]    frame_opcode,
    output logic          frame_fin,
    output logic [1:0]    reply,
    output logic          status
);
    import wsd_pkg::*;

    logic       valid_reg;
    logic       has_reg, eof_reg, fin_reg, status_reg;
    logic [7:0] byte_reg;
    logic [3:0] opcode_reg;
    reply_t     reply_reg;

    assign pop = !empty && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || !out_stall)
            valid_reg <= !empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            has_reg    <= item.has_byte;
            byte_reg   <= item.data ^ item.key;
            eof_reg    <= item.eof;
            opcode_reg <= item.opcode;
            fin_reg    <= item.fin;
            reply_reg  <= item.reply;
            status_reg <= item.status;
        end
    end

    assign out_valid    = valid_reg;
    assign has_byte     = has_reg;
    assign payload_byte = byte_reg;
    assign end_of_frame = eof_reg;
    assign frame_opcode = opcode_reg;
    assign frame_fin    = fin_reg;
    assign reply        = reply_reg;
    assign status       = status_reg;

endmodule

### sv/websocket_frame_deframer.sv
// Top level of the WebSocket receive deframer: parser, queue and output stage.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | rx_byte
//  output   | out_valid/ out_stall | has_byte payload_byte end_of_frame
//           |                      | frame_opcode frame_fin reply status
//  config   | cfg_we               | cfg_data (max_payload)
//
// One byte per cycle sustained while the output is not stalled. The parser
// updates its frame state in the cycle a byte is taken; its result enters
// the queue at the edge that takes the byte and the output register when free.
// in_stall rises only when the two-entry queue is full, i.e. when the output
// has been stalled long enough to back up the queue.
// Reset (rst_n low, asynchronous) clears the parse state, the queue and the
// output valid, and loads max_payload with 10240. No clearing pass is needed.
// After a close frame or an invalid frame, bytes are still taken but dropped
// until reset.
`timescale 1ns / 1ps
module websocket_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        has_byte,
    output logic [7:0]  payload_byte,
    output logic        end_of_frame,
    output logic [3:0]  frame_opcode,
    output logic        frame_fin,
    output logic [1:0]  reply,
    output logic        status
);
    import wsd_pkg::*;

    act_t front_item, queue_item;
    logic acc, push, pop, q_empty, q_full;

    // a byte is taken whenever the queue has room, even if it makes no result
    assign in_stall = q_full;
    assign acc      = in_valid && !q_full;

    wsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .acc      (acc),
        .rx_byte  (rx_byte),
        .push     (push),
        .act      (front_item)
    );

    wsd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (front_item),
        .pop     (pop),
        .rd_item (queue_item),
        .empty   (q_empty),
        .full    (q_full)
    );

    wsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (queue_item),
        .empty        (q_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .has_byte     (has_byte),
        .payload_byte (payload_byte),
        .end_of_frame (end_of_frame),
        .frame_opcode (frame_opcode),
        .frame_fin    (frame_fin),
        .reply        (reply),
        .status       (status)
    );

endmodule

### sv/wsd_checker.sv
// Port-level checks of the deframer, bound to the top level.
`timescale 1ns / 1ps
module wsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       has_byte,
    input logic [7:0] payload_byte,
    input logic       end_of_frame,
    input logic [1:0] reply,
    input logic       status
);
    import wsd_pkg::*;

    // stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_byte))
        else $error("stalled result changed");

    // replies only come with a clean frame end
    a_reply_eof: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply != REPLY_NONE |-> end_of_frame && !status)
        else $error("reply without frame end");

    // an item with no byte is either an empty frame end or an error
    a_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> end_of_frame || status)
        else $error("empty result without cause");

    // nothing pending right out of reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid out of reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .has_byte     (has_byte),
    .payload_byte (payload_byte),
    .end_of_frame (end_of_frame),
    .reply        (reply),
    .status       (status)
);
